// ----- sv/vtd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vtd_pkg
// Types shared by the trellis decoder controller, datapath and top level.
// ----------------------------------------------------------------------------
package vtd_pkg;

    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_EMIS   = 2'd1,
        OP_TRANS  = 2'd2,
        OP_FINISH = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLOSE_OPEN,
        ST_CLOSE_FIN,
        ST_OPEN,
        ST_LOAD,
        ST_EMIT,
        ST_FETCH
    } state_t;

    typedef struct packed {
        op_t         opcode;
        logic [3:0]  cand_index;
        logic [3:0]  prev_index;
        logic [4:0]  cand_count;
        logic [15:0] cost;
    } in_t;

    typedef struct packed {
        logic [5:0]  step_index;
        logic [3:0]  chosen_cand;
        logic [31:0] path_cost;
        logic        last;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic sweep;
        logic open_col;
        logic load_first;
        logic load_next;
        logic clear;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic step_zero;
        logic step_full;
        logic sweep_last;
        logic path_last;
    } sts_t;

endpackage
`default_nettype wire

// ----- sv/vtd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vtd_ctrl
// Sequencer: column close sweep, column open, path walk and beat handoff.
// ----------------------------------------------------------------------------
module vtd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    input  wire vtd_pkg::op_t  opcode,
    input  wire logic          res_stall,
    input  wire vtd_pkg::sts_t sts,
    output logic               item_stall,
    output logic               res_valid,
    output vtd_pkg::cmd_t      cmd
);

    vtd_pkg::state_t state_reg, state_next;
    logic            accept;

    assign accept = (state_reg == vtd_pkg::ST_IDLE) && item_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vtd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vtd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        vtd_pkg::OP_BEGIN:
                        begin
                            if (!sts.step_full)
                            begin
                                state_next = sts.step_zero ? vtd_pkg::ST_OPEN
                                                           : vtd_pkg::ST_CLOSE_OPEN;
                            end
                        end
                        vtd_pkg::OP_FINISH:
                        begin
                            if (!sts.step_zero)
                            begin
                                state_next = vtd_pkg::ST_CLOSE_FIN;
                            end
                        end
                        default:
                        begin
                            state_next = vtd_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            vtd_pkg::ST_CLOSE_OPEN:
            begin
                if (sts.sweep_last)
                begin
                    state_next = vtd_pkg::ST_OPEN;
                end
            end
            vtd_pkg::ST_CLOSE_FIN:
            begin
                if (sts.sweep_last)
                begin
                    state_next = vtd_pkg::ST_LOAD;
                end
            end
            vtd_pkg::ST_OPEN:
            begin
                state_next = vtd_pkg::ST_IDLE;
            end
            vtd_pkg::ST_LOAD:
            begin
                state_next = vtd_pkg::ST_EMIT;
            end
            vtd_pkg::ST_EMIT:
            begin
                if (!res_stall)
                begin
                    state_next = sts.path_last ? vtd_pkg::ST_IDLE : vtd_pkg::ST_FETCH;
                end
            end
            vtd_pkg::ST_FETCH:
            begin
                state_next = vtd_pkg::ST_EMIT;
            end
            default:
            begin
                state_next = vtd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.accept     = accept;
        cmd.sweep      = (state_reg == vtd_pkg::ST_CLOSE_OPEN) ||
                         (state_reg == vtd_pkg::ST_CLOSE_FIN);
        cmd.open_col   = (state_reg == vtd_pkg::ST_OPEN);
        cmd.load_first = (state_reg == vtd_pkg::ST_LOAD);
        cmd.load_next  = (state_reg == vtd_pkg::ST_FETCH);
        cmd.clear      = (state_reg == vtd_pkg::ST_EMIT) && !res_stall && sts.path_last;
        item_stall     = (state_reg != vtd_pkg::ST_IDLE);
        res_valid      = (state_reg == vtd_pkg::ST_EMIT);
    end

endmodule
`default_nettype wire

// ----- sv/vtd_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vtd_datapath
// Column cost arrays, add-compare-select, back-pointer memory, path registers.
// ----------------------------------------------------------------------------
module vtd_datapath #(
    parameter int MAX_CANDS = 16,
    parameter int MAX_STEPS = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire vtd_pkg::in_t  item,
    input  wire vtd_pkg::cmd_t cmd,
    output vtd_pkg::out_t      res,
    output vtd_pkg::sts_t      sts
);

    localparam int IW    = (MAX_CANDS > 1) ? $clog2(MAX_CANDS) : 1;
    localparam int CNTW  = $clog2(MAX_CANDS + 1);
    localparam int XW    = (CNTW > 5) ? CNTW : 5;
    localparam int SW    = $clog2(MAX_STEPS + 1);
    localparam int SIW   = $clog2(MAX_STEPS);
    localparam int OW    = (SIW > 6) ? SIW : 6;
    localparam int CDW   = (IW > 4) ? IW : 4;
    localparam int DEPTH = MAX_STEPS * MAX_CANDS;
    localparam int AW    = $clog2(DEPTH);

    logic [31:0]     prev_cost_reg [MAX_CANDS];
    logic [31:0]     best_cost_reg [MAX_CANDS];
    logic [3:0]      best_pred_reg [MAX_CANDS];
    logic [15:0]     emis_reg      [MAX_CANDS];
    logic [3:0]      bp_mem        [DEPTH];
    logic [3:0]      bp_rd_reg;

    logic [SW-1:0]   step_reg;
    logic [CNTW-1:0] prev_count_reg, cur_count_reg;
    logic [4:0]      pend_cnt_reg;
    logic [IW-1:0]   sweep_idx_reg;
    logic [IW-1:0]   min_idx_reg;
    logic [31:0]     min_cost_reg;

    logic [SIW-1:0]  s_out_reg;
    logic [CDW-1:0]  cand_out_reg;
    logic [31:0]     cost_out_reg;
    logic            last_out_reg;

    logic [XW-1:0]   ci_x, pi_x;
    logic [IW-1:0]   ci_i, pi_i;
    logic            emis_ok, trans_ok, trans_win;
    logic [32:0]     trans_sum_w, sweep_sum_w;
    logic [31:0]     trans_sum, sweep_sum, sweep_cost;
    logic            sweep_live;
    logic [CNTW-1:0] open_cnt;
    logic [SIW-1:0]  close_step, s_dec;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [OW-1:0]   s_w;

    assign ci_x = XW'(item.cand_index);
    assign pi_x = XW'(item.prev_index);
    assign ci_i = ci_x[IW-1:0];
    assign pi_i = pi_x[IW-1:0];

    assign emis_ok  = cmd.accept && (item.opcode == vtd_pkg::OP_EMIS) &&
                      (ci_x < XW'(cur_count_reg));
    assign trans_ok = cmd.accept && (item.opcode == vtd_pkg::OP_TRANS) &&
                      (step_reg >= SW'(2)) && (ci_x < XW'(cur_count_reg)) &&
                      (pi_x < XW'(prev_count_reg));

    // saturating accumulate of the previous column cost and the edge cost
    assign trans_sum_w = {1'b0, prev_cost_reg[pi_i]} + 33'(item.cost);
    assign trans_sum   = trans_sum_w[32] ? '1 : trans_sum_w[31:0];
    assign trans_win   = (trans_sum < best_cost_reg[ci_i]) ||
                         ((trans_sum == best_cost_reg[ci_i]) &&
                          (item.prev_index < best_pred_reg[ci_i]));

    assign close_step  = SIW'(step_reg - SW'(1));
    assign sweep_live  = CNTW'(sweep_idx_reg) < cur_count_reg;
    assign sweep_sum_w = {1'b0, best_cost_reg[sweep_idx_reg]} +
                         33'(emis_reg[sweep_idx_reg]);
    assign sweep_sum   = sweep_sum_w[32] ? '1 : sweep_sum_w[31:0];

    always_comb
    begin
        if (!sweep_live)
        begin
            sweep_cost = '1;
        end
        else if (step_reg == SW'(1))
        begin
            sweep_cost = 32'(emis_reg[sweep_idx_reg]);
        end
        else
        begin
            sweep_cost = sweep_sum;
        end
    end

    always_comb
    begin
        if (pend_cnt_reg == 5'd0)
        begin
            open_cnt = CNTW'(1);
        end
        else if (XW'(pend_cnt_reg) > XW'(MAX_CANDS))
        begin
            open_cnt = CNTW'(MAX_CANDS);
        end
        else
        begin
            open_cnt = CNTW'(pend_cnt_reg);
        end
    end

    assign s_dec   = s_out_reg - SIW'(1);
    assign wr_addr = AW'(close_step) * AW'(MAX_CANDS) + AW'(sweep_idx_reg);
    assign rd_addr = AW'(s_out_reg) * AW'(MAX_CANDS) + AW'(cand_out_reg[IW-1:0]);

    // back-pointer store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.sweep)
        begin
            bp_mem[wr_addr] <= best_pred_reg[sweep_idx_reg];
        end
        bp_rd_reg <= bp_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sweep)
        begin
            prev_cost_reg[sweep_idx_reg] <= sweep_cost;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_CANDS; k++)
            begin
                best_cost_reg[k] <= '1;
                best_pred_reg[k] <= '0;
                emis_reg[k]      <= '0;
            end
            step_reg       <= '0;
            prev_count_reg <= '0;
            cur_count_reg  <= '0;
            pend_cnt_reg   <= '0;
            sweep_idx_reg  <= '0;
            min_idx_reg    <= '0;
            min_cost_reg   <= '0;
            s_out_reg      <= '0;
            cand_out_reg   <= '0;
            cost_out_reg   <= '0;
            last_out_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.accept && (item.opcode == vtd_pkg::OP_BEGIN))
            begin
                pend_cnt_reg <= item.cand_count;
            end
            if (emis_ok)
            begin
                emis_reg[ci_i] <= item.cost;
            end
            if (trans_ok && trans_win)
            begin
                best_cost_reg[ci_i] <= trans_sum;
                best_pred_reg[ci_i] <= item.prev_index;
            end
            if (cmd.sweep)
            begin
                // running argmin over live candidates, lower index kept on ties
                if (sweep_idx_reg == '0)
                begin
                    min_idx_reg  <= '0;
                    min_cost_reg <= sweep_cost;
                end
                else if (sweep_live && (sweep_cost < min_cost_reg))
                begin
                    min_idx_reg  <= sweep_idx_reg;
                    min_cost_reg <= sweep_cost;
                end
                if (sweep_idx_reg == IW'(MAX_CANDS - 1))
                begin
                    sweep_idx_reg  <= '0;
                    prev_count_reg <= cur_count_reg;
                end
                else
                begin
                    sweep_idx_reg <= sweep_idx_reg + IW'(1);
                end
            end
            if (cmd.open_col || cmd.clear)
            begin
                for (int k = 0; k < MAX_CANDS; k++)
                begin
                    best_cost_reg[k] <= '1;
                    best_pred_reg[k] <= '0;
                    emis_reg[k]      <= '0;
                end
            end
            if (cmd.open_col)
            begin
                cur_count_reg <= open_cnt;
                step_reg      <= step_reg + SW'(1);
            end
            if (cmd.clear)
            begin
                step_reg       <= '0;
                prev_count_reg <= '0;
                cur_count_reg  <= '0;
            end
            if (cmd.load_first)
            begin
                s_out_reg    <= close_step;
                cand_out_reg <= CDW'(min_idx_reg);
                cost_out_reg <= min_cost_reg;
                last_out_reg <= (close_step == '0);
            end
            if (cmd.load_next)
            begin
                s_out_reg    <= s_dec;
                cand_out_reg <= CDW'(bp_rd_reg);
                last_out_reg <= (s_dec == '0);
            end
        end
    end

    assign s_w             = OW'(s_out_reg);
    assign res.step_index  = s_w[5:0];
    assign res.chosen_cand = cand_out_reg[3:0];
    assign res.path_cost   = cost_out_reg;
    assign res.last        = last_out_reg;

    assign sts.step_zero  = (step_reg == '0);
    assign sts.step_full  = (step_reg >= SW'(MAX_STEPS));
    assign sts.sweep_last = (sweep_idx_reg == IW'(MAX_CANDS - 1));
    assign sts.path_last  = last_out_reg;

endmodule
`default_nettype wire

// ----- sv/viterbi_trellis_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// viterbi_trellis_decoder
// HMM Viterbi decoder in the negative-log domain with path backtrack.
// ----------------------------------------------------------------------------
// Input channel (item/item_valid/item_stall) carries begin, emission,
// transition and finish beats; output channel (res/res_valid/res_stall)
// carries one beat per path entry, last step first, last set on step 0.
// A transition beat does one add-compare-select on a candidate entry; an
// emission beat stores the emission cost. A begin beat after the first
// closes the column: the sweep takes one candidate per cycle into the cost
// registers and the back-pointer memory. The first begin skips the sweep.
// Finish sweeps the last column with a running argmin, loads the first
// entry, then fetches each further entry from the back-pointer memory
// via its registered read port. item_stall is high whenever the block is
// not idle. A stalled result holds and the walk waits on res_stall.
// Reset clears the trellis; cost and back-pointer stores need no clearing.
// ----------------------------------------------------------------------------
module viterbi_trellis_decoder #(
    parameter int MAX_CANDS = 16,
    parameter int MAX_STEPS = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         item_valid,
    output logic              item_stall,
    input  wire vtd_pkg::in_t item,
    output logic              res_valid,
    input  wire logic         res_stall,
    output vtd_pkg::out_t     res
);

    vtd_pkg::cmd_t cmd;
    vtd_pkg::sts_t sts;

    vtd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .opcode     (item.opcode),
        .res_stall  (res_stall),
        .sts        (sts),
        .item_stall (item_stall),
        .res_valid  (res_valid),
        .cmd        (cmd)
    );

    vtd_datapath #(
        .MAX_CANDS (MAX_CANDS),
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .cmd   (cmd),
        .res   (res),
        .sts   (sts)
    );

    // no input taken while a path is being delivered
    a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> item_stall)
        else $error("input accepted during path delivery");

    // the path ends after the step 0 beat
    a_end_of_path: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && res.last) |=> !res_valid)
        else $error("beat after last");

    // consecutive entries walk down one step
    a_step_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && !res.last) |=> ##1
        (res_valid && (res.step_index == 6'($past(res.step_index, 2) - 6'd1))))
        else $error("path step not decremented");

endmodule
`default_nettype wire
